/* rtl/lbs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the linear blend skinning block.
// No dependencies; imported by every module of the block.
package lbs_pkg;

   // Parameter store geometry
   localparam int LBS_MAX_BONES = 16;
   localparam int MAT_ROWS      = 3;
   localparam int MAT_COLS      = 4;
   localparam logic [3:0] MAT_ENTRIES = 4'd12;

   // Weight of one in unsigned Q16
   localparam logic [16:0] WEIGHT_ONE = 17'h10000;

   // Command codes on the input word
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TERM = 1'b1;

   // Width of the row counter and row tags
   localparam int ROW_W = 2;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAT_ROWS - 1);

   // Input word
   typedef struct packed {
      logic               command;
      logic [3:0]         bone;
      logic [3:0]         entry;
      logic signed [31:0] param_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        weight;
      logic               last;
   } lbs_req_type;

   // Result word
   typedef struct packed {
      logic signed [31:0] def_x;
      logic signed [31:0] def_y;
      logic signed [31:0] def_z;
      logic               saturated;
   } lbs_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic             load;     // write one matrix entry from the input word
      logic             capture;  // latch a term word
      logic             issue;    // read one matrix row into the pipeline
      logic [ROW_W-1:0] row;      // row being issued
      logic             emit;     // produce the result and clear accumulators
   } lbs_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic bone_ok;    // latched bone lies inside the store
      logic pipe_busy;  // a row is still in flight
   } lbs_sts_type;

endpackage

/* rtl/linear_blend_skinning.sv */
`timescale 1ns / 1ps
// Linear blend skinning. A load word is written when accepted and does not raise
// busy; a term word holds busy for three row reads from the one-row-per-cycle
// matrix store and the drain of the four-stage multiply pipeline, so terms are
// accepted only while busy is low. A term whose bone lies outside the store skips
// the reads. The result strobe rises after a last term has drained; results cannot
// be held off. Sync reset clears control and accumulators.
module linear_blend_skinning #(
   parameter int MAX_BONES = lbs_pkg::LBS_MAX_BONES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lbs_pkg::lbs_req_type req,
   output logic                rsp_valid,
   output lbs_pkg::lbs_rsp_type rsp
);
   import lbs_pkg::*;

   lbs_cmd_type cmd;
   lbs_sts_type sts;

   lbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req.command),
      .req_last    (req.last),
      .sts         (sts),
      .busy        (busy),
      .cmd         (cmd)
   );

   lbs_datapath #(
      .MAX_BONES (MAX_BONES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

/* rtl/lbs_datapath.sv */
`timescale 1ns / 1ps
// Datapath: matrix store, four-stage row pipeline, accumulators and output clamp.
// Depends on lbs_pkg; driven by lbs_ctrl through command/status structs.
module lbs_datapath #(
   parameter int MAX_BONES = lbs_pkg::LBS_MAX_BONES
) (
   input  logic                clock,
   input  logic                reset,
   input  lbs_pkg::lbs_req_type req,
   input  lbs_pkg::lbs_cmd_type cmd,
   output lbs_pkg::lbs_sts_type sts,
   output logic                rsp_valid,
   output lbs_pkg::lbs_rsp_type rsp
);
   import lbs_pkg::*;

   localparam int MAT_DEPTH = MAX_BONES * MAT_ROWS;
   localparam int AW        = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int TW        = 50;

   // Matrix store: one row of four entries per address
   logic [MAT_COLS-1:0][31:0] mat_mem_ff [MAT_DEPTH];
   logic [MAT_COLS-1:0][31:0] mat_row_ff;

   // Latched term word
   logic [3:0]         bone_ff;
   logic signed [31:0] pos_ff [3];
   logic [16:0]        w_ff;

   // Pipeline valids and row tags
   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic [ROW_W-1:0] r1_ff, r2_ff, r3_ff, r4_ff;

   // Pipeline payload
   logic signed [63:0]  prod_ff [3];
   logic signed [63:0]  prod_in [3];
   logic signed [31:0]  m3_ff;
   logic signed [TW-1:0] t_ff, t_in;
   logic signed [51:0]  hp_ff, hp_in;
   logic [32:0]         lp_ff, lp_in;

   // Accumulators and result
   logic [63:0]  acc_ff [3];
   logic [63:0]  acc_in [3];
   logic [63:0]  contrib;
   lbs_rsp_type  rsp_ff, rsp_in;
   logic         rsp_valid_ff;

   // Addresses
   logic [6:0]    wr_wide, rd_wide;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en;
   logic          ld_bone_ok;

   // bone * 3 + row
   assign wr_wide = {2'b00, req.bone, 1'b0} + {3'b000, req.bone} + {5'b00000, req.entry[3:2]};
   assign rd_wide = {2'b00, bone_ff, 1'b0} + {3'b000, bone_ff} + {5'b00000, cmd.row};
   assign wr_addr = AW'(wr_wide);
   assign rd_addr = AW'(rd_wide);

   assign ld_bone_ok = ({5'd0, req.bone} < 9'(MAX_BONES));
   assign wr_en      = cmd.load && ld_bone_ok && (req.entry < MAT_ENTRIES);

   assign sts.bone_ok   = ({5'd0, bone_ff} < 9'(MAX_BONES));
   assign sts.pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff;

   // Store write and registered row read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mat_mem_ff[wr_addr][req.entry[1:0]] <= req.param_value;
      end
      if (cmd.issue) begin
         mat_row_ff <= mat_mem_ff[rd_addr];
      end
   end

   // Term capture, weight clipped to one
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bone_ff   <= req.bone;
         pos_ff[0] <= req.pos_x;
         pos_ff[1] <= req.pos_y;
         pos_ff[2] <= req.pos_z;
         w_ff      <= (req.weight > WEIGHT_ONE) ? WEIGHT_ONE : req.weight;
      end
   end

   // Stage 2: three matrix products, exact Q32.32
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = $signed(mat_row_ff[c]) * pos_ff[c];
      end
   end

   // Stage 3: floor each product to Q.16 and add the translation
   assign t_in = TW'(prod_ff[0] >>> 16) + TW'(prod_ff[1] >>> 16)
               + TW'(prod_ff[2] >>> 16) + TW'(m3_ff);

   // Stage 4: weight split into high and low halves of t
   assign hp_in = $signed(t_ff[TW-1:16]) * $signed({1'b0, w_ff});
   assign lp_in = t_ff[15:0] * w_ff;

   // floor(t * w / 2^16)
   assign contrib = 64'(hp_ff) + 64'(lp_ff[32:16]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      m3_ff   <= $signed(mat_row_ff[3]);
      t_ff    <= t_in;
      hp_ff   <= hp_in;
      lp_ff   <= lp_in;
      r1_ff   <= cmd.row;
      r2_ff   <= r1_ff;
      r3_ff   <= r2_ff;
      r4_ff   <= r3_ff;
   end

   // Accumulate and clear on emit
   always_comb begin
      acc_in = acc_ff;
      if (v4_ff) begin
         acc_in[r4_ff] = acc_ff[r4_ff] + contrib;
      end
      if (cmd.emit) begin
         for (int i = 0; i < 3; i++) begin
            acc_in[i] = '0;
         end
      end
   end

   // Clamp a 64-bit Q.16 accumulator to 32 bits
   function automatic logic [32:0] clamp64(input logic [63:0] a);
      logic [32:0] res;
      if (!a[63] && (|a[62:31])) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (a[63] && !(&a[62:31])) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, a[31:0]};
      end
      return res;
   endfunction

   always_comb begin
      logic [32:0] cx, cy, cz;
      cx = clamp64(acc_ff[0]);
      cy = clamp64(acc_ff[1]);
      cz = clamp64(acc_ff[2]);
      rsp_in.def_x     = $signed(cx[31:0]);
      rsp_in.def_y     = $signed(cy[31:0]);
      rsp_in.def_z     = $signed(cz[31:0]);
      rsp_in.saturated = cx[32] | cy[32] | cz[32];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= cmd.emit;
         acc_ff       <= acc_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/lbs_ctrl.sv */
`timescale 1ns / 1ps
// Controller: accepts words, walks the three matrix rows, waits for the drain.
// Depends on lbs_pkg; commands lbs_datapath through command/status structs.
module lbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_command,
   input  logic                req_last,
   input  lbs_pkg::lbs_sts_type sts,
   output logic                busy,
   output lbs_pkg::lbs_cmd_type cmd
);
   import lbs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             last_ff, last_in;
   logic             accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      last_in     = last_ff;
      cmd.load    = 1'b0;
      cmd.capture = 1'b0;
      cmd.issue   = 1'b0;
      cmd.row     = row_ff;
      cmd.emit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  last_in     = req_last;
                  row_in      = '0;
                  state_in    = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            // an out-of-range bone contributes nothing
            cmd.issue = sts.bone_ok;
            if (row_ff == LAST_ROW) begin
               row_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               cmd.emit = last_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         last_ff  <= last_in;
      end
   end

endmodule

/* tb/linear_blend_skinning_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for linear_blend_skinning: directed rows, then random vertex streams.
// Depends on lbs_pkg (word types, command codes, store geometry) and the linear_blend_skinning RTL.
module linear_blend_skinning_tb;
   import lbs_pkg::*;

   localparam int ENTRIES_PER_BONE = MAT_ROWS * MAT_COLS;
   localparam int STORE_DEPTH      = LBS_MAX_BONES * ENTRIES_PER_BONE;
   localparam int QUIET_LIMIT      = 2000;
   localparam int TARGET_WORDS     = 1650;
   localparam int SETTLE_CYCLES    = 20;
   localparam logic [31:0] Q_ONE   = 32'h0001_0000;

   // One row of the directed table; a pinned result replaces the predicted one
   typedef struct {
      lbs_req_type word;
      bit          pinned;
      lbs_rsp_type result;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   lbs_req_type req;
   logic        rsp_valid;
   lbs_rsp_type rsp;

   // Pinned expectation travels with the word being offered
   logic        pin_valid;
   lbs_rsp_type pin_rsp;

   // Predictor state
   logic signed [31:0] rig_matrix [STORE_DEPTH];
   logic [63:0]        acc_x = '0;
   logic [63:0]        acc_y = '0;
   logic [63:0]        acc_z = '0;
   lbs_rsp_type        pending_vertices [$];

   int  mismatches  = 0;
   int  quiet_cycles = 0;
   bit  burst       = 1'b0;
   int  issued      = 0;

   linear_blend_skinning dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
   endtask

   // Weighted contribution of one matrix row: floor(t * w / 2^16)
   function automatic logic [63:0] row_blend(input int base, input logic signed [31:0] x,
                                             input logic signed [31:0] y,
                                             input logic signed [31:0] z,
                                             input logic [16:0] wt);
      longint             t;
      logic signed [95:0] t_wide;
      logic signed [95:0] w_wide;
      logic signed [95:0] prod;
      t = ((longint'(rig_matrix[base])     * longint'(x)) >>> 16)
        + ((longint'(rig_matrix[base + 1]) * longint'(y)) >>> 16)
        + ((longint'(rig_matrix[base + 2]) * longint'(z)) >>> 16)
        + longint'(rig_matrix[base + 3]);
      t_wide = t;
      w_wide = $signed({79'd0, wt});
      prod   = t_wide * w_wide;
      return prod[79:16];
   endfunction

   // Clamp a 64-bit Q.16 sum to 32 bits; bit 32 flags clipping
   function automatic logic [32:0] clamp_coord(input logic [63:0] a);
      longint v;
      v = a;
      if (v > longint'(32'sh7FFF_FFFF))
         return {1'b1, 32'h7FFF_FFFF};
      else if (v < longint'(32'sh8000_0000))
         return {1'b1, 32'h8000_0000};
      return {1'b0, a[31:0]};
   endfunction

   // Advance the predictor by one accepted word
   task automatic apply_word(input lbs_req_type w, input bit pin, input lbs_rsp_type pinned);
      logic [16:0] wt;
      int          base;
      logic [32:0] cx;
      logic [32:0] cy;
      logic [32:0] cz;
      lbs_rsp_type vtx;
      if (w.command == CMD_LOAD) begin
         if (w.bone < LBS_MAX_BONES && w.entry < MAT_ENTRIES)
            rig_matrix[int'(w.bone) * ENTRIES_PER_BONE + int'(w.entry)] = w.param_value;
      end else begin
         wt = (w.weight > WEIGHT_ONE) ? WEIGHT_ONE : w.weight;
         if (w.bone < LBS_MAX_BONES) begin
            base = int'(w.bone) * ENTRIES_PER_BONE;
            acc_x += row_blend(base, w.pos_x, w.pos_y, w.pos_z, wt);
            acc_y += row_blend(base + MAT_COLS, w.pos_x, w.pos_y, w.pos_z, wt);
            acc_z += row_blend(base + 2 * MAT_COLS, w.pos_x, w.pos_y, w.pos_z, wt);
         end
         if (w.last) begin
            cx = clamp_coord(acc_x);
            cy = clamp_coord(acc_y);
            cz = clamp_coord(acc_z);
            vtx.def_x     = cx[31:0];
            vtx.def_y     = cy[31:0];
            vtx.def_z     = cz[31:0];
            vtx.saturated = cx[32] | cy[32] | cz[32];
            pending_vertices = {pending_vertices, (pin ? pinned : vtx)};
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
         end
      end
   endtask

   task automatic check_vertex(input lbs_rsp_type got);
      lbs_rsp_type want;
      if (pending_vertices.size() == 0) begin
         report_mismatch("vertex with none pending", got.def_x, '0);
      end else begin
         want = pending_vertices.pop_front();
         if (got.def_x !== want.def_x) report_mismatch("def_x", got.def_x, want.def_x);
         if (got.def_y !== want.def_y) report_mismatch("def_y", got.def_y, want.def_y);
         if (got.def_z !== want.def_z) report_mismatch("def_z", got.def_z, want.def_z);
         if (got.saturated !== want.saturated)
            report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
      end
   endtask

   // Results are checked before the word accepted at the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid)
            check_vertex(rsp);
         if (start && !busy)
            apply_word(req, pin_valid, pin_rsp);
         if ((start && !busy) || rsp_valid)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Q16.16 value: mostly small, some full range, some extremes
   function automatic logic [31:0] pick_q16(input int span);
      int mode;
      int v;
      mode = $urandom_range(0, 15);
      if (mode < 11) begin
         v = int'($urandom_range(0, 2 * span)) - span;
         return v;
      end else if (mode < 14) begin
         return $urandom;
      end else if (mode == 14) begin
         return 32'h7FFF_FFFF;
      end
      return 32'h8000_0000;
   endfunction

   function automatic logic [16:0] pick_weight();
      case ($urandom_range(0, 7))
         0, 1, 2: return 17'($urandom_range(0, 65536));
         3:       return WEIGHT_ONE;
         4:       return '0;
         5:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 131071));
      endcase
   endfunction

   // Every field random; callers overwrite the ones that matter
   function automatic lbs_req_type noise_word();
      lbs_req_type w;
      w.command     = 1'($urandom);
      w.bone        = 4'($urandom);
      w.entry       = 4'($urandom);
      w.param_value = $urandom;
      w.pos_x       = $urandom;
      w.pos_y       = $urandom;
      w.pos_z       = $urandom;
      w.weight      = 17'($urandom);
      w.last        = 1'($urandom);
      return w;
   endfunction

   function automatic lbs_req_type load_word(input logic [3:0] bone, input logic [3:0] entry,
                                             input logic [31:0] value);
      lbs_req_type w;
      w             = noise_word();
      w.command     = CMD_LOAD;
      w.bone        = bone;
      w.entry       = entry;
      w.param_value = value;
      return w;
   endfunction

   function automatic lbs_req_type term_word(input logic [3:0] bone, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] z,
                                             input logic [16:0] wt, input logic last);
      lbs_req_type w;
      w         = noise_word();
      w.command = CMD_TERM;
      w.bone    = bone;
      w.pos_x   = x;
      w.pos_y   = y;
      w.pos_z   = z;
      w.weight  = wt;
      w.last    = last;
      return w;
   endfunction

   function automatic plan_row_type free_row(input lbs_req_type w);
      plan_row_type r;
      r.word   = w;
      r.pinned = 1'b0;
      r.result = '0;
      return r;
   endfunction

   function automatic plan_row_type pinned_row(input lbs_req_type w, input logic [31:0] ex,
                                               input logic [31:0] ey, input logic [31:0] ez,
                                               input logic sat);
      plan_row_type r;
      r.word   = w;
      r.pinned = 1'b1;
      r.result = '{def_x: ex, def_y: ey, def_z: ez, saturated: sat};
      return r;
   endfunction

   // Offer one word after a random gap and hold it until the block takes it
   task automatic send_word(input lbs_req_type w, input bit pin, input lbs_rsp_type pr);
      int gap;
      if ($urandom_range(0, 39) == 0)
         burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req       <= w;
      pin_valid <= pin;
      pin_rsp   <= pr;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_vertices();
      @(negedge clock);
      start <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   initial begin
      plan_row_type plan [$];
      int           order [STORE_DEPTH];
      int           j;
      int           tmp;
      int           nterms;
      int           roll;
      bit           paused;
      lbs_req_type  w;

      reset     = 1'b1;
      start     = 1'b0;
      req       = '0;
      pin_valid = 1'b0;
      pin_rsp   = '0;
      paused    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Bone 0 as identity; diagonal entries are 0, 5 and 10. Last set on a load.
      for (int e = 0; e < ENTRIES_PER_BONE; e++) begin
         w      = load_word(4'd0, 4'(e), (e % 5 == 0) ? Q_ONE : '0);
         w.last = (e == ENTRIES_PER_BONE - 1);
         plan   = {plan, free_row(w)};
      end
      plan = {plan, pinned_row(term_word(4'd0, Q_ONE, 32'h0002_0000, 32'hFFFD_0000,
                                         WEIGHT_ONE, 1'b1),
                               Q_ONE, 32'h0002_0000, 32'hFFFD_0000, 1'b0)};
      // Weight above one behaves as one
      plan = {plan, pinned_row(term_word(4'd0, Q_ONE, 32'hFFFF_0000, 32'h0000_8000,
                                         17'h1_FFFF, 1'b1),
                               Q_ONE, 32'hFFFF_0000, 32'h0000_8000, 1'b0)};
      plan = {plan, pinned_row(term_word(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                         17'd0, 1'b1), '0, '0, '0, 1'b0)};
      // Two half-weight terms add up to the position
      plan = {plan, free_row(term_word(4'd0, 32'h0002_0000, 32'h0004_0000, 32'hFFFE_0000,
                                       17'h0_8000, 1'b0))};
      plan = {plan, pinned_row(term_word(4'd0, 32'h0002_0000, 32'h0004_0000, 32'hFFFE_0000,
                                         17'h0_8000, 1'b1),
                               32'h0002_0000, 32'h0004_0000, 32'hFFFE_0000, 1'b0)};
      // Positive and negative clipping
      plan = {plan, free_row(term_word(4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       WEIGHT_ONE, 1'b0))};
      plan = {plan, pinned_row(term_word(4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         WEIGHT_ONE, 1'b1),
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1)};
      plan = {plan, free_row(term_word(4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       WEIGHT_ONE, 1'b0))};
      plan = {plan, pinned_row(term_word(4'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         WEIGHT_ONE, 1'b1),
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1)};
      // Extreme matrix entries, left to the predictor
      plan = {plan, free_row(load_word(4'd0, 4'd0, 32'h8000_0000))};
      plan = {plan, free_row(load_word(4'd0, 4'd3, 32'h7FFF_FFFF))};
      plan = {plan, free_row(load_word(4'd0, 4'd7, 32'hFFFF_FFFF))};
      plan = {plan, free_row(term_word(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                       17'h0_FFFF, 1'b1))};

      foreach (plan[i]) begin
         send_word(plan[i].word, plan[i].pinned, plan[i].result);
         issued++;
      end
      drain_vertices();

      // Fill the whole store in shuffled order before any random term
      for (int i = 0; i < STORE_DEPTH; i++)
         order[i] = i;
      for (int i = STORE_DEPTH - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         send_word(load_word(4'(order[i] / ENTRIES_PER_BONE), 4'(order[i] % ENTRIES_PER_BONE),
                             pick_q16(131072)), 1'b0, '0);
         issued++;
      end

      // Mostly whole vertices, with stray loads and ignored loads mixed in
      while (issued < TARGET_WORDS) begin
         roll = $urandom_range(0, 19);
         if (roll < 16) begin
            nterms = $urandom_range(1, 4);
            for (int k = 0; k < nterms; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_word(load_word(4'($urandom), 4'($urandom_range(0, 11)),
                                      pick_q16(131072)), 1'b0, '0);
                  issued++;
               end
               w = term_word(4'($urandom), pick_q16(262144), pick_q16(262144),
                             pick_q16(262144), pick_weight(), k == nterms - 1);
               send_word(w, 1'b0, '0);
               issued++;
            end
         end else if (roll < 19) begin
            send_word(load_word(4'($urandom), 4'($urandom_range(0, 11)), pick_q16(131072)),
                      1'b0, '0);
            issued++;
         end else begin
            // Entry past the matrix: the store must stay untouched
            send_word(load_word(4'($urandom), 4'($urandom_range(12, 15)), $urandom), 1'b0, '0);
            issued++;
         end
         if (!paused && issued > TARGET_WORDS / 2) begin
            paused = 1'b1;
            drain_vertices();
         end
      end

      drain_vertices();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
